// File: src/socks_pkg.sv
// ----------------------------------------------------------------------------
// socks_pkg: shared types and codes of the SOCKS5 UDP header parser
// Result item layout, result kinds, drop reasons and queue sizing.
// ----------------------------------------------------------------------------
package socks_pkg;

  // Result kinds.
  localparam logic [2:0] K_ADDR    = 3'd0;
  localparam logic [2:0] K_PAYLOAD = 3'd1;
  localparam logic [2:0] K_HEADER  = 3'd2;
  localparam logic [2:0] K_ACCEPT  = 3'd3;
  localparam logic [2:0] K_DROP    = 3'd4;

  // Drop reasons.
  localparam logic [2:0] R_NONE     = 3'd0;
  localparam logic [2:0] R_FOREIGN  = 3'd1;
  localparam logic [2:0] R_RESERVED = 3'd2;
  localparam logic [2:0] R_TYPE     = 3'd3;
  localparam logic [2:0] R_TRUNC    = 3'd4;

  // Address type codes as reported in results.
  localparam logic [1:0] AT_IPV4   = 2'd0;
  localparam logic [1:0] AT_DOMAIN = 2'd1;
  localparam logic [1:0] AT_IPV6   = 2'd2;

  // Address type bytes on the wire.
  localparam logic [7:0] ATYP_IPV4   = 8'd1;
  localparam logic [7:0] ATYP_DOMAIN = 8'd3;
  localparam logic [7:0] ATYP_IPV6   = 8'd4;

  // Address lengths in bytes.
  localparam logic [7:0] IPV4_LEN = 8'd4;
  localparam logic [7:0] IPV6_LEN = 8'd16;

  // Result queue depth: room for two results per item plus slack.
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  // One result item.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [1:0]  addr_type;
    logic [15:0] dest_port;
    logic [2:0]  drop_reason;
    logic        run_end;
  } result_t;

  // Results produced by one accepted item, handed to the result queue.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

// File: src/socks_in_if.sv
// ----------------------------------------------------------------------------
// socks_in_if: input channel of the parser
// Carries one datagram byte with its framing flags and sender identity.
// ----------------------------------------------------------------------------
interface socks_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;
  logic [31:0] sender_addr;
  logic [15:0] sender_port;

  modport source (
    output valid, data_byte, first_byte, last_byte, sender_addr, sender_port,
    input  ready
  );
  modport sink (
    input  valid, data_byte, first_byte, last_byte, sender_addr, sender_port,
    output ready
  );
endinterface

// File: src/socks_out_if.sv
// ----------------------------------------------------------------------------
// socks_out_if: result channel of the parser
// Carries one result item: address, header, payload or end marker.
// ----------------------------------------------------------------------------
interface socks_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  out_byte;
  logic [1:0]  addr_type;
  logic [15:0] dest_port;
  logic [2:0]  drop_reason;
  logic        run_end;

  modport source (
    output valid, kind, out_byte, addr_type, dest_port, drop_reason, run_end,
    input  ready
  );
  modport sink (
    input  valid, kind, out_byte, addr_type, dest_port, drop_reason, run_end,
    output ready
  );
endinterface

// File: src/socks_parse_core.sv
// ----------------------------------------------------------------------------
// socks_parse_core: per-byte header parser state and result generation
// Holds the parse state and the bound client, and computes the results of
// each accepted byte in a single pass of combinational logic.
// ----------------------------------------------------------------------------
module socks_parse_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               first_byte,
  input  logic               last_byte,
  input  logic [31:0]        sender_addr,
  input  logic [15:0]        sender_port,
  output socks_pkg::push_t   push
);

  // Parse phases.
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_RSV     = 4'd1;
  localparam logic [3:0] PH_ATYP    = 4'd2;
  localparam logic [3:0] PH_DLEN    = 4'd3;
  localparam logic [3:0] PH_ADDR    = 4'd4;
  localparam logic [3:0] PH_PORT_HI = 4'd5;
  localparam logic [3:0] PH_PORT_LO = 4'd6;
  localparam logic [3:0] PH_PAYLOAD = 4'd7;
  localparam logic [3:0] PH_DROP    = 4'd8;

  logic [3:0]  phase_r,   phase_nxt;
  logic [1:0]  hdr_off_r, hdr_off_nxt;
  logic [7:0]  addr_rem_r, addr_rem_nxt;
  logic [7:0]  port_hi_r, port_hi_nxt;
  logic [1:0]  atype_r,   atype_nxt;
  logic [2:0]  drop_r,    drop_nxt;
  logic        bound_r,   bound_nxt;
  logic [31:0] caddr_r,   caddr_nxt;
  logic [15:0] cport_r,   cport_nxt;

  socks_pkg::result_t trunc_item, byte_item, end_item;
  logic               has_trunc;
  logic               emit_byte;
  logic               emit_end;
  logic               skip;

  // Step logic: one byte in, up to two results out.
  always_comb begin
    phase_nxt    = phase_r;
    hdr_off_nxt  = hdr_off_r;
    addr_rem_nxt = addr_rem_r;
    port_hi_nxt  = port_hi_r;
    atype_nxt    = atype_r;
    drop_nxt     = drop_r;
    bound_nxt    = bound_r;
    caddr_nxt    = caddr_r;
    cport_nxt    = cport_r;
    trunc_item   = '0;
    byte_item    = '0;
    end_item     = '0;
    has_trunc    = 1'b0;
    emit_byte    = 1'b0;
    emit_end     = 1'b0;
    skip         = 1'b0;

    // Start of a datagram, closing any open one as truncated.
    if (first_byte) begin
      if (phase_r != PH_IDLE) begin
        trunc_item.kind        = socks_pkg::K_DROP;
        trunc_item.drop_reason = socks_pkg::R_TRUNC;
        has_trunc              = 1'b1;
      end
      hdr_off_nxt  = 2'd0;
      addr_rem_nxt = 8'd0;
      port_hi_nxt  = 8'd0;
      atype_nxt    = socks_pkg::AT_IPV4;
      drop_nxt     = socks_pkg::R_NONE;
      phase_nxt    = PH_RSV;
      if (!bound_r) begin
        bound_nxt = 1'b1;
        caddr_nxt = sender_addr;
        cport_nxt = sender_port;
      end else if (sender_addr != caddr_r || sender_port != cport_r) begin
        drop_nxt  = socks_pkg::R_FOREIGN;
        phase_nxt = PH_DROP;
      end
    end else if (phase_r == PH_IDLE) begin
      skip = 1'b1;
    end

    if (!skip) begin
      // Header field decode for the current phase.
      case (phase_nxt)
        PH_RSV: begin
          if (data_byte != 8'd0) begin
            drop_nxt  = socks_pkg::R_RESERVED;
            phase_nxt = PH_DROP;
          end else if (hdr_off_nxt == 2'd2) begin
            hdr_off_nxt = 2'd0;
            phase_nxt   = PH_ATYP;
          end else begin
            hdr_off_nxt = hdr_off_nxt + 2'd1;
          end
        end
        PH_ATYP: begin
          if (data_byte == socks_pkg::ATYP_IPV4) begin
            atype_nxt    = socks_pkg::AT_IPV4;
            addr_rem_nxt = socks_pkg::IPV4_LEN;
            phase_nxt    = PH_ADDR;
          end else if (data_byte == socks_pkg::ATYP_DOMAIN) begin
            atype_nxt = socks_pkg::AT_DOMAIN;
            phase_nxt = PH_DLEN;
          end else if (data_byte == socks_pkg::ATYP_IPV6) begin
            atype_nxt    = socks_pkg::AT_IPV6;
            addr_rem_nxt = socks_pkg::IPV6_LEN;
            phase_nxt    = PH_ADDR;
          end else begin
            drop_nxt  = socks_pkg::R_TYPE;
            phase_nxt = PH_DROP;
          end
        end
        PH_DLEN: begin
          addr_rem_nxt = data_byte;
          phase_nxt    = (data_byte == 8'd0) ? PH_PORT_HI : PH_ADDR;
        end
        PH_ADDR: begin
          byte_item.kind      = socks_pkg::K_ADDR;
          byte_item.out_byte  = data_byte;
          byte_item.addr_type = atype_nxt;
          emit_byte           = 1'b1;
          addr_rem_nxt        = addr_rem_nxt - 8'd1;
          if (addr_rem_nxt == 8'd0) begin
            phase_nxt = PH_PORT_HI;
          end
        end
        PH_PORT_HI: begin
          port_hi_nxt = data_byte;
          phase_nxt   = PH_PORT_LO;
        end
        PH_PORT_LO: begin
          byte_item.kind      = socks_pkg::K_HEADER;
          byte_item.addr_type = atype_nxt;
          byte_item.dest_port = {port_hi_nxt, data_byte};
          emit_byte           = 1'b1;
          phase_nxt           = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          byte_item.kind      = socks_pkg::K_PAYLOAD;
          byte_item.out_byte  = data_byte;
          byte_item.addr_type = atype_nxt;
          emit_byte           = 1'b1;
        end
        default: begin
        end
      endcase

      // End of datagram: accepted or dropped.
      if (last_byte) begin
        emit_end = 1'b1;
        if (phase_nxt == PH_PAYLOAD) begin
          end_item.kind      = socks_pkg::K_ACCEPT;
          end_item.addr_type = atype_nxt;
        end else if (phase_nxt == PH_DROP) begin
          end_item.kind        = socks_pkg::K_DROP;
          end_item.drop_reason = drop_nxt;
        end else begin
          end_item.kind        = socks_pkg::K_DROP;
          end_item.drop_reason = socks_pkg::R_TRUNC;
        end
        phase_nxt = PH_IDLE;
      end
    end
  end

  // Pack results in order and mark the last one.
  always_comb begin
    push = '0;
    if (accept) begin
      if (has_trunc) begin
        push.res0  = trunc_item;
        push.count = 2'd1;
      end
      if (emit_byte) begin
        if (push.count == 2'd0) push.res0 = byte_item;
        else                    push.res1 = byte_item;
        push.count = push.count + 2'd1;
      end
      if (emit_end) begin
        if (push.count == 2'd0) push.res0 = end_item;
        else                    push.res1 = end_item;
        push.count = push.count + 2'd1;
      end
      if (push.count == 2'd1) push.res0.run_end = 1'b1;
      if (push.count == 2'd2) push.res1.run_end = 1'b1;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      hdr_off_r  <= 2'd0;
      addr_rem_r <= 8'd0;
      port_hi_r  <= 8'd0;
      atype_r    <= socks_pkg::AT_IPV4;
      drop_r     <= socks_pkg::R_NONE;
      bound_r    <= 1'b0;
      caddr_r    <= 32'd0;
      cport_r    <= 16'd0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      hdr_off_r  <= hdr_off_nxt;
      addr_rem_r <= addr_rem_nxt;
      port_hi_r  <= port_hi_nxt;
      atype_r    <= atype_nxt;
      drop_r     <= drop_nxt;
      bound_r    <= bound_nxt;
      caddr_r    <= caddr_nxt;
      cport_r    <= cport_nxt;
    end
  end

endmodule

// File: src/socks_res_fifo.sv
// ----------------------------------------------------------------------------
// socks_res_fifo: result queue between the parser and the result channel
// Takes up to two results per cycle and delivers one per cycle in order while head_ready is high.
// ----------------------------------------------------------------------------
module socks_res_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  socks_pkg::push_t   push,
  output logic               room,
  output logic               head_valid,
  output socks_pkg::result_t head,
  input  logic               head_ready
);

  localparam int PtrW = socks_pkg::RES_PTR_W;
  localparam int CntW = socks_pkg::RES_CNT_W;

  socks_pkg::result_t mem_r [socks_pkg::RES_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r,  count_nxt;
  logic            pop;

  // Queue status and head of line.
  assign room       = (count_r <= CntW'(socks_pkg::RES_DEPTH - 2));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign pop        = head_valid && head_ready;

  // Pointer and fill arithmetic.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PtrW'(push.count);
    rd_ptr_nxt = rd_ptr_r + PtrW'(pop);
    count_nxt  = count_r + CntW'(push.count) - CntW'(pop);
  end

  // Storage writes, one or two entries per item.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_r + PtrW'(1)] <= push.res1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: src/socks5_udp_header_parser.sv
// The results of an accepted byte appear on the result channel in the cycle
// after acceptance when the result queue is empty.
// Throughput: one byte per cycle; a byte that causes two results yields them
// one by one, and input stalls while the four-entry result queue has
// fewer than two free entries. Reset (synchronous, active low) returns the
// parser to idle, unbinds the client and empties the queue.
// ----------------------------------------------------------------------------
// socks5_udp_header_parser: SOCKS5 UDP relay header parser
// Binds the first sender, checks and decodes the header byte by byte and
// emits address, header, payload and end-of-datagram result items.
// ----------------------------------------------------------------------------
module socks5_udp_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  socks_in_if.sink    in_ch,
  socks_out_if.source out_ch
);

  socks_pkg::push_t   push;
  socks_pkg::result_t head;
  logic               room;
  logic               head_valid;
  logic               in_accept;

  // Input handshake.
  assign in_ch.ready = room;
  assign in_accept   = in_ch.valid && room;

  socks_parse_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .data_byte   (in_ch.data_byte),
    .first_byte  (in_ch.first_byte),
    .last_byte   (in_ch.last_byte),
    .sender_addr (in_ch.sender_addr),
    .sender_port (in_ch.sender_port),
    .push        (push)
  );

  socks_res_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .head_ready (out_ch.ready)
  );

  // Result channel.
  assign out_ch.valid       = head_valid;
  assign out_ch.kind        = head.kind;
  assign out_ch.out_byte    = head.out_byte;
  assign out_ch.addr_type   = head.addr_type;
  assign out_ch.dest_port   = head.dest_port;
  assign out_ch.drop_reason = head.drop_reason;
  assign out_ch.run_end     = head.run_end;

endmodule

// File: tb/sv/socks5_udp_header_parser_tb.sv
// ----------------------------------------------------------------------------
// socks5_udp_header_parser_tb: self-checking testbench of the UDP header parser
// A directed table walks binding, every address type and every drop reason.
// Random datagrams follow, most well formed and the rest faulty. A
// byte-level parser model predicts the result items, and every item that
// leaves the block is compared against the oldest expectation.
// ----------------------------------------------------------------------------
module socks5_udp_header_parser_tb;

  localparam int                 MAX_CYCLES   = 1_000_000;
  localparam int                 RANDOM_ITEMS = 1150;
  localparam int                 LONG_HOLD    = 300;
  localparam int                 DRAIN_CYCLES = 16;
  localparam logic [31:0]        CLI_ADDR     = 32'hFFFF_FFFF;
  localparam logic [15:0]        CLI_PORT     = 16'hFFFF;
  localparam socks_pkg::result_t NO_RES       = '0;

  // Parser phases of the model.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RSV     = 4'd1;
  localparam logic [3:0] S_ATYP    = 4'd2;
  localparam logic [3:0] S_DLEN    = 4'd3;
  localparam logic [3:0] S_ADDR    = 4'd4;
  localparam logic [3:0] S_PORT_HI = 4'd5;
  localparam logic [3:0] S_PORT_LO = 4'd6;
  localparam logic [3:0] S_PAYLOAD = 4'd7;
  localparam logic [3:0] S_DISCARD = 4'd8;

  typedef struct {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [31:0] sender_addr;
    logic [15:0] sender_port;
  } in_item_t;

  // One stimulus row; n_typed < 0 means the model supplies the results.
  typedef struct {
    in_item_t           item;
    int                 n_typed;
    socks_pkg::result_t r0;
    socks_pkg::result_t r1;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  socks_in_if  in_ch ();
  socks_out_if out_ch ();

  socks5_udp_header_parser DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // Model state.
  logic [3:0]   phase_q    = S_IDLE;
  logic [1:0]   hdr_idx    = '0;
  logic [7:0]   addr_left  = '0;
  logic [7:0]   port_hi_q  = '0;
  logic [1:0]   cur_at     = socks_pkg::AT_IPV4;
  logic [2:0]   why_q      = socks_pkg::R_NONE;
  logic         bound_q    = 1'b0;
  logic [31:0]  bound_addr = '0;
  logic [15:0]  bound_port = '0;

  socks_pkg::result_t byte_results[$];
  socks_pkg::result_t pending_results[$];
  stim_row_t          dir_rows[$];
  int                 mismatches    = 0;
  int                 items_sent    = 0;
  int                 cycle_count   = 0;
  bit                 hold_off_req  = 1'b0;

  function automatic socks_pkg::result_t make_result(logic [2:0] k, logic [7:0] b,
                                                     logic [1:0] at, logic [15:0] p,
                                                     logic [2:0] why, logic fin);
    socks_pkg::result_t r;
    r.kind        = k;
    r.out_byte    = b;
    r.addr_type   = at;
    r.dest_port   = p;
    r.drop_reason = why;
    r.run_end     = fin;
    return r;
  endfunction

  function automatic stim_row_t row_of(logic [7:0] b, logic f, logic l, logic [31:0] a,
                                       logic [15:0] p, int n, socks_pkg::result_t r0,
                                       socks_pkg::result_t r1);
    stim_row_t s;
    s.item.data_byte   = b;
    s.item.first_byte  = f;
    s.item.last_byte   = l;
    s.item.sender_addr = a;
    s.item.sender_port = p;
    s.n_typed          = n;
    s.r0               = r0;
    s.r1               = r1;
    return s;
  endfunction

  function automatic void add_row(stim_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void add_result(logic [2:0] k, logic [7:0] b, logic [1:0] at,
                                     logic [15:0] p, logic [2:0] why);
    byte_results.insert(byte_results.size(), make_result(k, b, at, p, why, 1'b0));
  endfunction

  function automatic string fmt_result(socks_pkg::result_t r);
    return $sformatf("kind=%0d byte=%02h atype=%0d port=%04h reason=%0d end=%0b",
                     r.kind, r.out_byte, r.addr_type, r.dest_port, r.drop_reason,
                     r.run_end);
  endfunction

  // Parser model: advances the state by one byte and fills byte_results.
  function automatic void predict_byte(in_item_t it);
    byte_results.delete();
    if (it.first_byte) begin
      // A new datagram closes one that is still open.
      if (phase_q != S_IDLE) begin
        add_result(socks_pkg::K_DROP, 8'h00, socks_pkg::AT_IPV4, 16'h0000,
                   socks_pkg::R_TRUNC);
      end
      hdr_idx   = '0;
      addr_left = '0;
      port_hi_q = '0;
      cur_at    = socks_pkg::AT_IPV4;
      why_q     = socks_pkg::R_NONE;
      phase_q   = S_RSV;
      if (!bound_q) begin
        bound_q    = 1'b1;
        bound_addr = it.sender_addr;
        bound_port = it.sender_port;
      end else if (it.sender_addr != bound_addr || it.sender_port != bound_port) begin
        why_q   = socks_pkg::R_FOREIGN;
        phase_q = S_DISCARD;
      end
    end else if (phase_q == S_IDLE) begin
      return;
    end

    case (phase_q)
      S_RSV: begin
        if (it.data_byte != 8'h00) begin
          why_q   = socks_pkg::R_RESERVED;
          phase_q = S_DISCARD;
        end else if (hdr_idx >= 2'd2) begin
          hdr_idx = '0;
          phase_q = S_ATYP;
        end else begin
          hdr_idx = hdr_idx + 2'd1;
        end
      end
      S_ATYP: begin
        if (it.data_byte == socks_pkg::ATYP_IPV4) begin
          cur_at    = socks_pkg::AT_IPV4;
          addr_left = socks_pkg::IPV4_LEN;
          phase_q   = S_ADDR;
        end else if (it.data_byte == socks_pkg::ATYP_DOMAIN) begin
          cur_at  = socks_pkg::AT_DOMAIN;
          phase_q = S_DLEN;
        end else if (it.data_byte == socks_pkg::ATYP_IPV6) begin
          cur_at    = socks_pkg::AT_IPV6;
          addr_left = socks_pkg::IPV6_LEN;
          phase_q   = S_ADDR;
        end else begin
          why_q   = socks_pkg::R_TYPE;
          phase_q = S_DISCARD;
        end
      end
      S_DLEN: begin
        addr_left = it.data_byte;
        phase_q   = (it.data_byte == 8'h00) ? S_PORT_HI : S_ADDR;
      end
      S_ADDR: begin
        add_result(socks_pkg::K_ADDR, it.data_byte, cur_at, 16'h0000, socks_pkg::R_NONE);
        addr_left = addr_left - 8'd1;
        if (addr_left == 8'd0) phase_q = S_PORT_HI;
      end
      S_PORT_HI: begin
        port_hi_q = it.data_byte;
        phase_q   = S_PORT_LO;
      end
      S_PORT_LO: begin
        add_result(socks_pkg::K_HEADER, 8'h00, cur_at, {port_hi_q, it.data_byte},
                   socks_pkg::R_NONE);
        phase_q = S_PAYLOAD;
      end
      S_PAYLOAD: begin
        add_result(socks_pkg::K_PAYLOAD, it.data_byte, cur_at, 16'h0000,
                   socks_pkg::R_NONE);
      end
      default: begin
      end
    endcase

    // The last byte closes the datagram with its verdict.
    if (it.last_byte) begin
      if (phase_q == S_PAYLOAD) begin
        add_result(socks_pkg::K_ACCEPT, 8'h00, cur_at, 16'h0000, socks_pkg::R_NONE);
      end else if (phase_q == S_DISCARD) begin
        add_result(socks_pkg::K_DROP, 8'h00, socks_pkg::AT_IPV4, 16'h0000, why_q);
      end else begin
        add_result(socks_pkg::K_DROP, 8'h00, socks_pkg::AT_IPV4, 16'h0000,
                   socks_pkg::R_TRUNC);
      end
      phase_q = S_IDLE;
    end

    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].run_end = 1'b1;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one item, waits for its acceptance and records what it should cause.
  task automatic send_item(stim_row_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= r.item.data_byte;
    in_ch.first_byte  <= r.item.first_byte;
    in_ch.last_byte   <= r.item.last_byte;
    in_ch.sender_addr <= r.item.sender_addr;
    in_ch.sender_port <= r.item.sender_port;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_byte(r.item);
    if (r.n_typed < 0) begin
      foreach (byte_results[i]) pending_results.insert(pending_results.size(), byte_results[i]);
    end else begin
      if (r.n_typed > 0) pending_results.insert(pending_results.size(), r.r0);
      if (r.n_typed > 1) pending_results.insert(pending_results.size(), r.r1);
    end
  endtask

  // Builds one random datagram, well formed or with one fault, and sends it, or offers stray bytes.
  task automatic send_datagram();
    logic [7:0]  dg[$];
    logic [7:0]  b;
    logic [31:0] a;
    logic [15:0] p;
    int          roll;
    int          len;
    int          cut;
    bit          open_end;
    a        = CLI_ADDR;
    p        = CLI_PORT;
    open_end = 1'b0;
    roll     = $urandom_range(99);

    // Bytes outside a datagram are offered now and then.
    if (roll >= 97) begin
      repeat ($urandom_range(1, 3))
        send_item(row_of(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), $urandom,
                         16'($urandom_range(16'hFFFF)), -1, NO_RES, NO_RES));
      return;
    end

    // Well-formed header, address, port and payload.
    dg = {8'h00, 8'h00, 8'h00};
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        dg.insert(dg.size(), socks_pkg::ATYP_IPV4);
        len = int'(socks_pkg::IPV4_LEN);
      end
      4, 5, 6: begin
        dg.insert(dg.size(), socks_pkg::ATYP_DOMAIN);
        cut = $urandom_range(99);
        if (cut < 10) len = 0;
        else if (cut < 97) len = $urandom_range(1, 12);
        else len = $urandom_range(200, 255);
        dg.insert(dg.size(), len[7:0]);
      end
      default: begin
        dg.insert(dg.size(), socks_pkg::ATYP_IPV6);
        len = int'(socks_pkg::IPV6_LEN);
      end
    endcase
    repeat (len) dg.insert(dg.size(), 8'($urandom_range(255)));
    repeat (2) dg.insert(dg.size(), 8'($urandom_range(255)));
    cut = $urandom_range(99);
    if (cut < 15) len = 0;
    else if (cut < 90) len = $urandom_range(1, 6);
    else len = $urandom_range(7, 40);
    repeat (len) dg.insert(dg.size(), 8'($urandom_range(255)));

    // Inject at most one fault.
    if (roll < 65) begin
    end else if (roll < 72) begin
      case ($urandom_range(2))
        0: begin
          a = $urandom;
          p = 16'($urandom_range(16'hFFFF));
        end
        1: a = CLI_ADDR ^ (32'd1 << $urandom_range(31));
        default: p = CLI_PORT ^ (16'd1 << $urandom_range(15));
      endcase
      if (a == CLI_ADDR && p == CLI_PORT) p = ~p;
    end else if (roll < 78) begin
      dg[$urandom_range(2)] = 8'($urandom_range(1, 255));
    end else if (roll < 84) begin
      do b = 8'($urandom_range(255));
      while (b == socks_pkg::ATYP_IPV4 || b == socks_pkg::ATYP_DOMAIN ||
             b == socks_pkg::ATYP_IPV6);
      dg[3] = b;
    end else if (roll < 91) begin
      cut = $urandom_range(1, dg.size());
      while (dg.size() > cut) void'(dg.pop_back());
    end else begin
      open_end = 1'b1;
    end

    foreach (dg[i]) begin
      send_item(row_of(dg[i], i == 0, (i == dg.size() - 1) && !open_end, a, p,
                       -1, NO_RES, NO_RES));
      items_sent++;
    end
  endtask

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    socks_pkg::result_t got;
    socks_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = make_result(out_ch.kind, out_ch.out_byte, out_ch.addr_type, out_ch.dest_port,
                        out_ch.drop_reason, out_ch.run_end);
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %s", $time,
                 fmt_result(got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: result mismatch, expected %s", $time, fmt_result(want));
          $display("%0t:                  actual   %s", $time, fmt_result(got));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("[socks5_udp_header_parser] ERROR");
      $finish;
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Stimulus: directed table, then random datagrams.
  initial begin : stimulus
    bit held;
    bit paused;
    held   = 1'b0;
    paused = 1'b0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.data_byte   <= '0;
    in_ch.first_byte  <= 1'b0;
    in_ch.last_byte   <= 1'b0;
    in_ch.sender_addr <= '0;
    in_ch.sender_port <= '0;

    // Stray byte while idle, then an IPv4 datagram that binds the all-ones sender.
    add_row(row_of(8'hAA, 1'b0, 1'b1, 32'h0, 16'h0, 0, NO_RES, NO_RES));
    add_row(row_of(8'h00, 1'b1, 1'b0, CLI_ADDR, CLI_PORT, 0, NO_RES, NO_RES));
    add_row(row_of(8'h00, 1'b0, 1'b0, CLI_ADDR, CLI_PORT, 0, NO_RES, NO_RES));
    add_row(row_of(8'h00, 1'b0, 1'b0, CLI_ADDR, CLI_PORT, 0, NO_RES, NO_RES));
    add_row(row_of(socks_pkg::ATYP_IPV4, 1'b0, 1'b0, CLI_ADDR, CLI_PORT, 0,
                   NO_RES, NO_RES));
    add_row(row_of(8'hFF, 1'b0, 1'b0, CLI_ADDR, CLI_PORT, 1,
                   make_result(socks_pkg::K_ADDR, 8'hFF, socks_pkg::AT_IPV4, 16'h0,
                               socks_pkg::R_NONE, 1'b1),
                   NO_RES));
    add_row(row_of(8'h00, 1'b0, 1'b0, CLI_ADDR, CLI_PORT, 1,
                   make_result(socks_pkg::K_ADDR, 8'h00, socks_pkg::AT_IPV4, 16'h0,
                               socks_pkg::R_NONE, 1'b1),
                   NO_RES));
    add_row(row_of(8'h80, 1'b0, 1'b0, CLI_ADDR, CLI_PORT, -1, NO_RES, NO_RES));
    add_row(row_of(8'h7F, 1'b0, 1'b0, CLI_ADDR, CLI_PORT, -1, NO_RES, NO_RES));
    add_row(row_of(8'hFF, 1'b0, 1'b0, CLI_ADDR, CLI_PORT, 0, NO_RES, NO_RES));
    add_row(row_of(8'hFF, 1'b0, 1'b0, CLI_ADDR, CLI_PORT, 1,
                   make_result(socks_pkg::K_HEADER, 8'h00, socks_pkg::AT_IPV4, 16'hFFFF,
                               socks_pkg::R_NONE, 1'b1),
                   NO_RES));
    add_row(row_of(8'h00, 1'b0, 1'b1, CLI_ADDR, CLI_PORT, 2,
                   make_result(socks_pkg::K_PAYLOAD, 8'h00, socks_pkg::AT_IPV4, 16'h0,
                               socks_pkg::R_NONE, 1'b0),
                   make_result(socks_pkg::K_ACCEPT, 8'h00, socks_pkg::AT_IPV4, 16'h0,
                               socks_pkg::R_NONE, 1'b1)));
    // Foreign sender, nonzero reserved byte, unknown address type.
    add_row(row_of(8'h00, 1'b1, 1'b1, 32'h0, 16'h0, 1,
                   make_result(socks_pkg::K_DROP, 8'h00, socks_pkg::AT_IPV4, 16'h0,
                               socks_pkg::R_FOREIGN, 1'b1),
                   NO_RES));
    add_row(row_of(8'hFF, 1'b1, 1'b1, CLI_ADDR, CLI_PORT, 1,
                   make_result(socks_pkg::K_DROP, 8'h00, socks_pkg::AT_IPV4, 16'h0,
                               socks_pkg::R_RESERVED, 1'b1),
                   NO_RES));
    add_row(row_of(8'h00, 1'b1, 1'b0, CLI_ADDR, CLI_PORT, 0, NO_RES, NO_RES));
    add_row(row_of(8'h00, 1'b0, 1'b0, CLI_ADDR, CLI_PORT, 0, NO_RES, NO_RES));
    add_row(row_of(8'h00, 1'b0, 1'b0, CLI_ADDR, CLI_PORT, 0, NO_RES, NO_RES));
    add_row(row_of(8'hFF, 1'b0, 1'b1, CLI_ADDR, CLI_PORT, 1,
                   make_result(socks_pkg::K_DROP, 8'h00, socks_pkg::AT_IPV4, 16'h0,
                               socks_pkg::R_TYPE, 1'b1),
                   NO_RES));
    // Short datagram.
    add_row(row_of(8'h00, 1'b1, 1'b0, CLI_ADDR, CLI_PORT, 0, NO_RES, NO_RES));
    add_row(row_of(8'h00, 1'b0, 1'b1, CLI_ADDR, CLI_PORT, 1,
                   make_result(socks_pkg::K_DROP, 8'h00, socks_pkg::AT_IPV4, 16'h0,
                               socks_pkg::R_TRUNC, 1'b1),
                   NO_RES));
    // Domain of length zero with an empty payload.
    add_row(row_of(8'h00, 1'b1, 1'b0, CLI_ADDR, CLI_PORT, -1, NO_RES, NO_RES));
    add_row(row_of(8'h00, 1'b0, 1'b0, CLI_ADDR, CLI_PORT, -1, NO_RES, NO_RES));
    add_row(row_of(8'h00, 1'b0, 1'b0, CLI_ADDR, CLI_PORT, -1, NO_RES, NO_RES));
    add_row(row_of(socks_pkg::ATYP_DOMAIN, 1'b0, 1'b0, CLI_ADDR, CLI_PORT, -1,
                   NO_RES, NO_RES));
    add_row(row_of(8'h00, 1'b0, 1'b0, CLI_ADDR, CLI_PORT, -1, NO_RES, NO_RES));
    add_row(row_of(8'h12, 1'b0, 1'b0, CLI_ADDR, CLI_PORT, -1, NO_RES, NO_RES));
    add_row(row_of(8'h34, 1'b0, 1'b1, CLI_ADDR, CLI_PORT, -1, NO_RES, NO_RES));
    // Missing last byte, then an IPv6 datagram cut right after its type byte.
    add_row(row_of(8'h00, 1'b1, 1'b0, CLI_ADDR, CLI_PORT, 0, NO_RES, NO_RES));
    add_row(row_of(8'h00, 1'b1, 1'b0, CLI_ADDR, CLI_PORT, 1,
                   make_result(socks_pkg::K_DROP, 8'h00, socks_pkg::AT_IPV4, 16'h0,
                               socks_pkg::R_TRUNC, 1'b1),
                   NO_RES));
    add_row(row_of(8'h00, 1'b0, 1'b0, CLI_ADDR, CLI_PORT, 0, NO_RES, NO_RES));
    add_row(row_of(8'h00, 1'b0, 1'b0, CLI_ADDR, CLI_PORT, 0, NO_RES, NO_RES));
    add_row(row_of(socks_pkg::ATYP_IPV6, 1'b0, 1'b1, CLI_ADDR, CLI_PORT, 1,
                   make_result(socks_pkg::K_DROP, 8'h00, socks_pkg::AT_IPV4, 16'h0,
                               socks_pkg::R_TRUNC, 1'b1),
                   NO_RES));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i]);

    while (items_sent < RANDOM_ITEMS) begin
      // Hold the receiver off for a long stretch while bytes keep coming.
      if (!held && items_sent >= 300) begin
        held         = 1'b1;
        hold_off_req = 1'b1;
      end
      // Let the block run dry once.
      if (!paused && items_sent >= 700) begin
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_datagram();
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("[socks5_udp_header_parser] OK");
    end else begin
      $display("[socks5_udp_header_parser] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
src/socks_pkg.sv
src/socks_in_if.sv
src/socks_out_if.sv
src/socks_parse_core.sv
src/socks_res_fifo.sv
src/socks5_udp_header_parser.sv
tb/sv/socks5_udp_header_parser_tb.sv
